>>> hdl/scm_pkg.sv
`timescale 1ns / 1ps
package scm_pkg;
  localparam int MaxBlockDefault   = 2048;
  localparam int SampleBitsDefault = 16;
  localparam int FloorBits         = 45;
  localparam int CoefBits          = 16;
  localparam int CorrBits          = 16;
  localparam int SumBits           = 64;
  localparam int CfgIdxBits        = 2;
  localparam int CfgDataBits       = 45;

  localparam logic [CfgIdxBits-1:0] RegHold  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegFloor = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegCoef  = 2'd2;

  localparam logic [FloorBits-1:0] FloorReset = 45'd2147;
  localparam logic [CoefBits-1:0]  CoefReset  = 16'd13107;

  typedef struct packed {
    logic [CorrBits-1:0] correlation;
    logic [CorrBits-1:0] smoothed_correlation;
    logic                low_energy;
  } scm_result_t;
endpackage

>>> hdl/scm_if.sv
`timescale 1ns / 1ps
interface scm_in_if #(parameter int SampleBits = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] mid_sample;
  logic signed [SampleBits-1:0] side_sample;
  logic                         has_sample;
  logic                         last;
  modport source (output valid, mid_sample, side_sample, has_sample, last, input ready);
  modport sink (input valid, mid_sample, side_sample, has_sample, last, output ready);
endinterface

interface scm_out_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] correlation;
  logic signed [15:0] smoothed_correlation;
  logic               low_energy;
  modport source (output valid, correlation, smoothed_correlation, low_energy, input ready);
  modport sink (input valid, correlation, smoothed_correlation, low_energy, output ready);
endinterface

interface scm_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [44:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/scm_ram.sv
`timescale 1ns / 1ps
module scm_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/stereo_correlation_meter_unit.sv
`timescale 1ns / 1ps
// sample request: ring read, then three shared multiplies for lr, ll, rr; when the oldest
// pair leaves a full ring, its three products are subtracted first; marker without last: taken in idle
// block end: the result is formed by the 64-step shift-add product, the 64-step root and
// the 15-step divide (skipped when forced)
// one request at a time; a waiting result only holds back the next block end
// rst_ni asynchronously clears control state, sums and counters and sets config registers to defaults; ring not cleared
module stereo_correlation_meter_unit
  import scm_pkg::*;
#(
  parameter int MaxBlock   = MaxBlockDefault,
  parameter int SampleBits = SampleBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  scm_in_if.sink    in_i,
  scm_out_if.source out_o,
  scm_cfg_if.sink   cfg_i
);
  localparam int AddrBits = (MaxBlock > 1) ? $clog2(MaxBlock) : 1;
  localparam int FillBits = $clog2(MaxBlock + 1);
  localparam int LBits    = SampleBits + 1;

  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001,
    SRead  = 11'b00000000010,
    SMul   = 11'b00000000100,
    SPMul  = 11'b00000001000,
    SRoot  = 11'b00000010000,
    SRtCmp = 11'b00000100000,
    SCmp   = 11'b00001000000,
    SDiv   = 11'b00010000000,
    SSmth  = 11'b00100000000,
    SSmAdd = 11'b01000000000,
    SOut   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic hold_q;
  logic [FloorBits-1:0] floor_q;
  logic [CoefBits-1:0]  coef_q;
  logic [FillBits-1:0]  fill_q;
  logic [AddrBits-1:0]  wp_q;
  logic [SumBits-1:0]   lr_q, ll_q, rr_q;
  logic signed [15:0]   sv_q;
  logic                 seeded_q;
  logic signed [SampleBits-1:0] m_q, s_q;
  logic signed [SampleBits-1:0] om_q, os_q;
  logic                 last_q, sub_q;
  logic [1:0]           mstep_q;
  logic [6:0]           cnt_q;
  logic [127:0]         prod_q, sq_q;
  logic [63:0]          mc_q, res_q, mag_q;
  logic [14:0]          quo_q;
  logic signed [15:0]   corr_q;
  logic                 low_q, neg_q;
  logic signed [32:0]   smx_q;
  logic [SampleBits-1:0] rm_rd, rs_rd;
  scm_result_t          res_out_q;
  logic                 ovalid_q;

  wire cfg_fire = cfg_i.valid && cfg_i.ready;
  wire in_fire  = in_i.valid && in_i.ready;
  wire out_fire = out_o.valid && out_o.ready;
  wire emit     = (state_q == SOut) && (!ovalid_q || out_fire);
  wire ring_full = (fill_q >= FillBits'(MaxBlock));

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == SIdle);

  scm_ram #(.Width(SampleBits), .Depth(MaxBlock)) u_ram_mid (
    .clk_i, .we_i(in_fire && !hold_q && in_i.has_sample), .waddr_i(wp_q),
    .wdata_i(in_i.mid_sample), .raddr_i(wp_q), .rdata_o(rm_rd));
  scm_ram #(.Width(SampleBits), .Depth(MaxBlock)) u_ram_side (
    .clk_i, .we_i(in_fire && !hold_q && in_i.has_sample), .waddr_i(wp_q),
    .wdata_i(in_i.side_sample), .raddr_i(wp_q), .rdata_o(rs_rd));

  // shared multiplier operands for the per-sample products
  logic signed [SampleBits-1:0] pm, ps;
  logic signed [LBits-1:0] l_v, r_v, op_a, op_b;
  logic signed [2*LBits-1:0] prod_v;
  logic [SumBits-1:0] prod_x;
  always_comb begin
    pm = sub_q ? om_q : m_q;
    ps = sub_q ? os_q : s_q;
    l_v = LBits'(pm) + LBits'(ps);
    r_v = LBits'(pm) - LBits'(ps);
    unique case (mstep_q)
      2'd0:    begin op_a = l_v; op_b = r_v; end
      2'd1:    begin op_a = l_v; op_b = l_v; end
      default: begin op_a = r_v; op_b = r_v; end
    endcase
    prod_v = op_a * op_b;
    prod_x = SumBits'(prod_v);
  end

  logic [63:0] rem_v;
  logic [128:0] sq_try;
  logic [63:0] cand;
  always_comb begin
    rem_v  = res_q - mag_q;
    cand   = res_q | (64'd1 << cnt_q[5:0]);
    // (res + 2^b)^2 = res^2 + res*2^(b+1) + 2^(2b)
    sq_try = {1'b0, sq_q} + ({65'd0, res_q} << (cnt_q[5:0] + 7'd1))
             + (129'd1 << {cnt_q[5:0], 1'b0});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:  if (in_fire && !hold_q) begin
                if (in_i.has_sample) state_d = SRead;
                else if (in_i.last) state_d = SPMul;
              end
      SRead:  state_d = SMul;
      SMul:   if (mstep_q == 2'd2 && !(sub_q)) state_d = last_q ? SPMul : SIdle;
      SPMul:  if (cnt_q == 7'd63) state_d = SRoot;
      SRoot:  state_d = SRtCmp;
      SRtCmp: if (cnt_q == 7'd0) state_d = SCmp;
      SCmp:   state_d = (!(res_q <= {19'd0, floor_q}) && !(mag_q >= res_q)) ? SDiv : SSmth;
      SDiv:   if (cnt_q == 7'd14) state_d = SSmth;
      SSmth:  state_d = SSmAdd;
      SSmAdd: state_d = SOut;
      // wait here while the previous result is still pending
      SOut:   if (emit) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; hold_q <= 1'b0; floor_q <= FloorReset; coef_q <= CoefReset;
      fill_q <= '0; wp_q <= '0; lr_q <= '0; ll_q <= '0; rr_q <= '0;
      sv_q <= '0; seeded_q <= 1'b0; ovalid_q <= 1'b0; mstep_q <= '0; cnt_q <= '0;
      sub_q <= 1'b0; last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        unique case (cfg_i.index)
          RegHold:  hold_q  <= cfg_i.data[0];
          RegFloor: floor_q <= cfg_i.data;
          RegCoef:  coef_q  <= cfg_i.data[CoefBits-1:0];
          default: ;
        endcase
      end
      if (emit) ovalid_q <= 1'b1;
      else if (out_fire) ovalid_q <= 1'b0;
      unique case (state_q)
        SIdle: if (in_fire && !hold_q) begin
          m_q <= in_i.mid_sample; s_q <= in_i.side_sample;
          last_q <= in_i.last; mstep_q <= '0; cnt_q <= '0;
          prod_q <= '0; mc_q <= '0;
        end
        SRead: begin
          // ring data still holds the oldest pair here
          om_q <= rm_rd; os_q <= rs_rd;
          sub_q <= ring_full;
          if (!ring_full) fill_q <= fill_q + FillBits'(1);
          wp_q <= (wp_q == AddrBits'(MaxBlock - 1)) ? '0 : wp_q + AddrBits'(1);
        end
        SMul: begin
          unique case (mstep_q)
            2'd0:    lr_q <= sub_q ? lr_q - prod_x : lr_q + prod_x;
            2'd1:    ll_q <= sub_q ? ll_q - prod_x : ll_q + prod_x;
            default: rr_q <= sub_q ? rr_q - prod_x : rr_q + prod_x;
          endcase
          if (mstep_q == 2'd2) begin
            mstep_q <= '0;
            if (sub_q) sub_q <= 1'b0;
          end else mstep_q <= mstep_q + 2'd1;
        end
        // shift-add 64x64 product, one bit of rr per cycle
        SPMul: begin
          if (rr_q[cnt_q[5:0]]) prod_q <= prod_q + ({64'd0, ll_q} << cnt_q[5:0]);
          if (cnt_q == 7'd63) cnt_q <= 7'd63; else cnt_q <= cnt_q + 7'd1;
        end
        SRoot: begin
          res_q <= '0; sq_q <= '0; cnt_q <= 7'd63;
        end
        SRtCmp: begin
          if (sq_try <= {1'b0, prod_q}) begin
            res_q <= cand; sq_q <= sq_try[127:0];
          end
          cnt_q <= cnt_q - 7'd1;
          neg_q <= lr_q[63];
          mag_q <= lr_q[63] ? (~lr_q + 64'd1) : lr_q;
        end
        SCmp: begin
          quo_q <= '0; cnt_q <= '0;
          if (res_q <= {19'd0, floor_q}) begin
            low_q <= 1'b1; corr_q <= 16'sd32767;
          end else begin
            low_q <= 1'b0;
            if (mag_q >= res_q) corr_q <= neg_q ? -16'sd32768 : 16'sd32767;
          end
        end
        SDiv: begin
          if (mag_q >= rem_v) begin
            mag_q <= mag_q - rem_v; quo_q <= {quo_q[13:0], 1'b1};
          end else begin
            mag_q <= mag_q + mag_q; quo_q <= {quo_q[13:0], 1'b0};
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd14)
            corr_q <= neg_q ? -$signed({1'b0, quo_q[13:0], (mag_q >= rem_v)})
                            : $signed({1'b0, quo_q[13:0], (mag_q >= rem_v)});
        end
        SSmth: smx_q <= $signed({1'b0, coef_q}) * (17'(corr_q) - 17'(sv_q)) + 33'sd32768;
        SSmAdd: begin
          logic signed [17:0] n_v;
          n_v = 18'(sv_q) + 18'(smx_q >>> 16);
          if (!seeded_q) sv_q <= corr_q;
          else if (n_v > 18'sd32767) sv_q <= 16'sd32767;
          else if (n_v < -18'sd32768) sv_q <= -16'sd32768;
          else sv_q <= n_v[15:0];
          seeded_q <= 1'b1;
        end
        SOut: if (emit) begin
          res_out_q <= '{correlation: corr_q, smoothed_correlation: sv_q, low_energy: low_q};
          lr_q <= '0; ll_q <= '0; rr_q <= '0; fill_q <= '0; wp_q <= '0;
        end
        default: ;
      endcase
      if (state_q == SMul && mstep_q == 2'd2 && !sub_q && last_q) begin
        cnt_q <= '0; prod_q <= '0;
      end
    end
  end

  assign out_o.valid                = ovalid_q;
  assign out_o.correlation          = res_out_q.correlation;
  assign out_o.smoothed_correlation = res_out_q.smoothed_correlation;
  assign out_o.low_energy           = res_out_q.low_energy;
endmodule

>>> hdl/scm_checker.sv
`timescale 1ns / 1ps
module scm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid, out_ready,
  input logic signed [15:0] corr,
  input logic low
);
  a_low_forces_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && low) |-> (corr == 16'sd32767)) else $error("low energy without +1");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(corr) && $stable(low))
    else $error("result dropped");
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown({corr, low})) else $error("unknown result");
  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready, out_valid})) else $error("unknown handshake");
endmodule

bind stereo_correlation_meter_unit scm_checker u_scm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .corr(out_o.correlation), .low(out_o.low_energy));

>>> sim/tb_checker.sv
`timescale 1ns / 1ps
module tb_checker
  import scm_pkg::*;
#(
  parameter int MaxBlock = MaxBlockDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  scm_in_if     in_mon,
  scm_out_if    out_mon,
  scm_cfg_if    cfg_mon,
  output int    fail_count,
  output int    pending_count,
  output logic  accepted_o
);
  typedef struct {
    logic signed [15:0] corr;
    logic signed [15:0] smooth;
    logic               low;
  } meter_result_t;

  meter_result_t expected_q[$];

  logic               hold_en;
  logic [44:0]        floor_lvl;
  logic [15:0]        coef;
  logic signed [15:0] mid_ring[MaxBlock];
  logic signed [15:0] side_ring[MaxBlock];
  int                 fill;
  int                 wptr;
  logic [63:0]        acc_lr;
  logic [63:0]        acc_ll;
  logic [63:0]        acc_rr;
  logic signed [15:0] smooth_val;
  logic               seeded;

  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  task automatic accumulate(logic signed [15:0] m, logic signed [15:0] s, bit sub);
    logic signed [63:0] l;
    logic signed [63:0] r;
    l = 64'(m) + 64'(s);
    r = 64'(m) - 64'(s);
    if (sub) begin
      acc_lr -= l * r;
      acc_ll -= l * l;
      acc_rr -= r * r;
    end else begin
      acc_lr += l * r;
      acc_ll += l * l;
      acc_rr += r * r;
    end
  endtask

  task automatic close_block();
    meter_result_t      res;
    logic [63:0]        root;
    logic [63:0]        mag;
    bit                 neg;
    logic [14:0]        q;
    logic signed [63:0] x;
    logic signed [63:0] d;
    logic signed [63:0] nv;
    root = isqrt128({64'd0, acc_ll} * {64'd0, acc_rr});
    neg = acc_lr[63];
    mag = neg ? -acc_lr : acc_lr;
    res.low = 1'b0;
    if (root <= {19'd0, floor_lvl}) begin
      res.corr = 16'sd32767;
      res.low = 1'b1;
    end else if (mag >= root) begin
      res.corr = neg ? -16'sd32768 : 16'sd32767;
    end else begin
      // restoring divide, 15 quotient bits
      q = '0;
      for (int i = 0; i < 15; i++) begin
        q = q << 1;
        if (mag >= root - mag) begin
          mag = mag - (root - mag);
          q[0] = 1'b1;
        end else begin
          mag = mag + mag;
        end
      end
      res.corr = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
    if (!seeded) begin
      smooth_val = res.corr;
      seeded = 1'b1;
    end else begin
      x = $signed({48'd0, coef}) * (64'(res.corr) - 64'(smooth_val)) + 64'sd32768;
      d = (x >= 0) ? x / 65536 : -((-x + 65535) / 65536);
      nv = 64'(smooth_val) + d;
      if (nv > 32767) nv = 32767;
      if (nv < -32768) nv = -32768;
      smooth_val = nv[15:0];
    end
    res.smooth = smooth_val;
    expected_q.push_back(res);
    acc_lr = '0;
    acc_ll = '0;
    acc_rr = '0;
    fill = 0;
    wptr = 0;
  endtask

  assign pending_count = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    meter_result_t want;
    if (!rst_ni) begin
      hold_en = 1'b0;
      floor_lvl = FloorReset;
      coef = CoefReset;
      fill = 0;
      wptr = 0;
      acc_lr = '0;
      acc_ll = '0;
      acc_rr = '0;
      smooth_val = '0;
      seeded = 1'b0;
      fail_count = 0;
      accepted_o = 1'b0;
      expected_q.delete();
    end else begin
      accepted_o = (in_mon.valid && in_mon.ready) || (out_mon.valid && out_mon.ready)
                   || (cfg_mon.valid && cfg_mon.ready);
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          RegHold: hold_en = cfg_mon.data[0];
          RegFloor: floor_lvl = cfg_mon.data;
          RegCoef: coef = cfg_mon.data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready && !hold_en) begin
        if (in_mon.has_sample) begin
          if (fill >= MaxBlock) accumulate(mid_ring[wptr], side_ring[wptr], 1'b1);
          else fill++;
          mid_ring[wptr] = in_mon.mid_sample;
          side_ring[wptr] = in_mon.side_sample;
          accumulate(in_mon.mid_sample, in_mon.side_sample, 1'b0);
          wptr = (wptr + 1) % MaxBlock;
        end
        if (in_mon.last) close_block();
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result corr=%0d", out_mon.correlation);
        end else begin
          want = expected_q.pop_front();
          if (want.corr !== out_mon.correlation || want.smooth !== out_mon.smoothed_correlation
              || want.low !== out_mon.low_energy) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp corr=%0d smooth=%0d low=%0b got %0d %0d %0b",
                       want.corr, want.smooth, want.low, out_mon.correlation,
                       out_mon.smoothed_correlation, out_mon.low_energy);
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top
  import scm_pkg::*;
;

  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_count;
  logic accepted;
  bit   no_idle = 1'b0;
  bit   sink_hold = 1'b0;
  int   quiet_cycles = 0;

  scm_in_if  in_ch();
  scm_out_if out_ch();
  scm_cfg_if cfg_ch();

  stereo_correlation_meter_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  tb_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count), .accepted_o(accepted)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mid_sample = '0;
    in_ch.side_sample = '0;
    in_ch.has_sample = 1'b0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegHold;
    cfg_ch.data = '0;
  end

  // result sink with random stalls
  always @(negedge clk_i) begin
    if (sink_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    if (accepted || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // valid stays up between back-to-back requests; idling or drain lowers it
  task automatic send_sample(logic [15:0] m, logic [15:0] s, bit has, bit lst);
    while (!no_idle && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mid_sample <= m;
    in_ch.side_sample <= s;
    in_ch.has_sample <= has;
    in_ch.last <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic random_block(int len);
    logic [15:0] m;
    logic [15:0] s;
    int          style;
    style = int'($urandom_range(3));
    for (int i = 0; i < len; i++) begin
      m = 16'($urandom);
      s = 16'($urandom);
      // correlated, anti-correlated and tiny signals as well as noise
      if (style == 1) s = 16'(int'($urandom_range(300)) - 150);
      else if (style == 2) m = 16'(int'($urandom_range(300)) - 150);
      else if (style == 3) begin
        m = 16'(int'($urandom_range(6)) - 3);
        s = 16'(int'($urandom_range(6)) - 3);
      end
      send_sample(m, s, ($urandom_range(9) != 0), 1'b0);
    end
    send_sample(16'($urandom), 16'($urandom), 1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    int sent;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: empty block, extremes, pure mid, pure side, marker without last
    send_sample(16'h0000, 16'h0000, 1'b0, 1'b1);
    send_sample(16'h7fff, 16'h0000, 1'b1, 1'b1);
    send_sample(16'h0000, 16'h7fff, 1'b1, 1'b1);
    send_sample(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_sample(16'h7fff, 16'h8000, 1'b1, 1'b0);
    send_sample(16'hffff, 16'hffff, 1'b0, 1'b0);
    send_sample(16'h1234, 16'h0100, 1'b1, 1'b1);
    send_sample(16'h4000, 16'hc000, 1'b1, 1'b0);
    send_sample(16'h0001, 16'h0000, 1'b1, 1'b1);
    drain();
    write_reg(RegHold, 45'd1);
    send_sample(16'h1000, 16'h2000, 1'b1, 1'b0);
    send_sample(16'h1000, 16'h2000, 1'b1, 1'b1);
    drain();
    write_reg(RegHold, 45'd0);
    write_reg(RegFloor, 45'd0);
    write_reg(RegCoef, 45'd65535);
    send_sample(16'h0001, 16'h0001, 1'b1, 1'b1);
    send_sample(16'h3000, 16'hd000, 1'b1, 1'b1);
    drain();
    write_reg(RegCoef, 45'd0);
    send_sample(16'h2000, 16'h0500, 1'b1, 1'b1);
    drain();
    write_reg(RegFloor, 45'h1fff_ffff_ffff);
    send_sample(16'h7fff, 16'h0000, 1'b1, 1'b1);
    drain();
    write_reg(RegFloor, 45'd2147);
    write_reg(RegCoef, 45'd13107);
    // receiver holds off while items keep coming
    no_idle = 1'b1;
    sink_hold = 1'b1;
    fork
      begin
        repeat (1500) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      begin
        for (int k = 0; k < 12; k++) send_sample(16'($urandom), 16'($urandom), 1'b1, 1'b1);
        in_ch.valid <= 1'b0;
      end
    join
    no_idle = 1'b0;
    drain();
    // one block past a full ring so the oldest pairs leave
    for (int i = 0; i < 2100; i++)
      send_sample(16'($urandom), 16'($urandom_range(200)), 1'b1, 1'b0);
    send_sample(16'h0100, 16'h0000, 1'b1, 1'b1);
    drain();
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: write_reg(RegCoef, 45'($urandom_range(65535)));
        2: write_reg(RegFloor, 45'($urandom_range(100000)));
        3: write_reg(RegFloor, {13'd0, 32'($urandom)});
        4: write_reg(RegFloor, 45'd2147);
        default: ;
      endcase
      no_idle = (ph == 2);
      while (sent < 250 * (ph + 1)) begin
        random_block(int'($urandom_range(30)));
        sent += 16;
      end
      drain();
    end
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
